// ===== design/bgpt_pkg.sv =====
// Shared types and constants for the buddy group pair table.
// This package has no dependencies. The cell and the top level both use it.
`timescale 1ns / 1ps

package bgpt_pkg;

    localparam int ID_W   = 16;
    localparam int SLOT_W = 10;   // slot numbers for up to 1024 entries

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_LOAD   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_INVALID = 3'd1,
        STAT_EXISTS  = 3'd2,
        STAT_UNKNOWN = 3'd3,
        STAT_INUSE   = 3'd4,
        STAT_FULL    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    // Query token that walks down the row of cells, one cell per cycle.
    typedef struct packed {
        logic              valid;
        t_op               op;
        logic [ID_W-1:0]   gid;
        logic [ID_W-1:0]   pri;
        logic [ID_W-1:0]   sec;
        logic              allow;
        logic              pknown;
        logic              sknown;
        logic              key_hit;
        logic [SLOT_W-1:0] hit_idx;
        logic [ID_W-1:0]   hit_pri;
        logic [ID_W-1:0]   hit_sec;
        logic              free_hit;
        logic [SLOT_W-1:0] free_idx;
        logic              po_hit;
        logic [ID_W-1:0]   po_key;
        logic              so_hit;
        logic [ID_W-1:0]   so_key;
    } t_token;

    // Write command broadcast from the controller to every cell.
    typedef struct packed {
        logic              en;
        logic              clr;
        logic [SLOT_W-1:0] idx;
        logic [ID_W-1:0]   key;
        logic [ID_W-1:0]   pri;
        logic [ID_W-1:0]   sec;
    } t_wr;

endpackage

// ===== design/bgpt_cell.sv =====
// One table entry of the buddy group pair table, with its stage of the query row.
// It depends on bgpt_pkg for the token and write command types.
`timescale 1ns / 1ps

module bgpt_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bgpt_pkg::t_token i_tok,
    input  bgpt_pkg::t_wr    i_wr,
    output bgpt_pkg::t_token o_tok
);

    logic                          r_valid;
    logic [bgpt_pkg::ID_W-1:0]     r_key;
    logic [bgpt_pkg::ID_W-1:0]     r_pri;
    logic [bgpt_pkg::ID_W-1:0]     r_sec;
    logic                          r_tok_valid;
    bgpt_pkg::t_token              r_tok;
    bgpt_pkg::t_token              n_tok;

    localparam logic [bgpt_pkg::SLOT_W-1:0] MY_SLOT = bgpt_pkg::SLOT_W'(CELL_IDX);

    // The first matching valid entry wins each key and owner search field; the first invalid entry wins the free field.
    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && r_valid) begin
            if (!i_tok.key_hit && r_key == i_tok.gid) begin
                n_tok.key_hit = 1'b1;
                n_tok.hit_idx = MY_SLOT;
                n_tok.hit_pri = r_pri;
                n_tok.hit_sec = r_sec;
            end
            if (!i_tok.po_hit && (r_pri == i_tok.pri || r_sec == i_tok.pri)) begin
                n_tok.po_hit = 1'b1;
                n_tok.po_key = r_key;
            end
            if (!i_tok.so_hit && (r_pri == i_tok.sec || r_sec == i_tok.sec)) begin
                n_tok.so_hit = 1'b1;
                n_tok.so_key = r_key;
            end
        end
        if (i_tok.valid && !r_valid && !i_tok.free_hit) begin
            n_tok.free_hit = 1'b1;
            n_tok.free_idx = MY_SLOT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= i_tok.valid;
            if (i_wr.clr) begin
                r_valid <= 1'b0;
            end else if (i_wr.en && i_wr.idx == MY_SLOT) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
        if (!i_wr.clr && i_wr.en && i_wr.idx == MY_SLOT) begin
            r_key <= i_wr.key;
            r_pri <= i_wr.pri;
            r_sec <= i_wr.sec;
        end
    end

    always_comb begin
        o_tok       = r_tok;
        o_tok.valid = r_tok_valid;
    end

endmodule

// ===== design/buddy_group_pair_table.sv =====
// Buddy group pair table: an accepted item's token is registered by every cell in turn, then held
// as the finished token; the result is committed to o_valid once the output register is free.
// Items are taken one at a time; the next may be taken while a result still waits behind i_stall.
// Reset (synchronous, active low) empties the table and drops any pending result.
// Entry keys and targets are not reset; they are read only while the entry is valid.
// Depends on bgpt_pkg and bgpt_cell.
`timescale 1ns / 1ps

module buddy_group_pair_table #(
    parameter int MAX_GROUPS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_group_id,
    input  logic [15:0] i_primary_target,
    input  logic [15:0] i_secondary_target,
    input  logic        i_allow_update,
    input  logic        i_primary_known,
    input  logic        i_secondary_known,
    // Output channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic        o_found,
    output logic [15:0] o_primary_out,
    output logic [15:0] o_secondary_out
);

    // Each accepted beat becomes a query token. The token is injected into the
    // first cell and moves one cell per cycle; each cell notes whether its own
    // entry holds the key, is free, or owns one of the two targets. The first
    // hit along the row wins, which gives lowest-slot priority. When the token
    // leaves the last cell, the controller decides the status and issues at most
    // one write (or a clear) to the cells, and loads the output register.

    bgpt_pkg::t_token tok [0:MAX_GROUPS];
    bgpt_pkg::t_token n_inject;
    bgpt_pkg::t_token r_tok;
    bgpt_pkg::t_wr    wr;

    bgpt_pkg::t_state r_state;
    bgpt_pkg::t_state n_state;

    logic                       in_accept;
    logic                       commit;

    logic                       r_out_valid;
    bgpt_pkg::t_status          r_status;
    logic                       r_found;
    logic [bgpt_pkg::ID_W-1:0]  r_pri_out;
    logic [bgpt_pkg::ID_W-1:0]  r_sec_out;

    bgpt_pkg::t_status          res_status;
    logic                       res_found;
    logic [bgpt_pkg::ID_W-1:0]  res_pri;
    logic [bgpt_pkg::ID_W-1:0]  res_sec;

    // Only one query is in the row at a time, so input is taken in idle only.
    assign o_stall   = (r_state != bgpt_pkg::S_IDLE);
    assign in_accept = i_valid && !o_stall;

    // Token built from the accepted beat. Owner keys start at zero so that a
    // target with no owner compares as "no owner" at the end.
    always_comb begin
        n_inject          = '0;
        n_inject.valid    = in_accept;
        n_inject.op       = bgpt_pkg::t_op'(i_operation);
        n_inject.gid      = i_group_id;
        n_inject.pri      = i_primary_target;
        n_inject.sec      = i_secondary_target;
        n_inject.allow    = i_allow_update;
        n_inject.pknown   = i_primary_known;
        n_inject.sknown   = i_secondary_known;
    end

    assign tok[0] = n_inject;

    genvar g;
    generate
        for (g = 0; g < MAX_GROUPS; g++) begin : g_cell
            bgpt_cell #(
                .CELL_IDX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_tok   (tok[g]),
                .i_wr    (wr),
                .o_tok   (tok[g+1])
            );
        end
    endgenerate

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            bgpt_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_state = bgpt_pkg::S_SCAN;
                end
            end
            bgpt_pkg::S_SCAN: begin
                if (tok[MAX_GROUPS].valid) begin
                    n_state = bgpt_pkg::S_FINISH;
                end
            end
            bgpt_pkg::S_FINISH: begin
                if (commit) begin
                    n_state = bgpt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bgpt_pkg::S_IDLE;
            end
        endcase
    end

    // Output logic: the decision on the finished token. The result may only be
    // committed once the output register is free or is being taken this cycle.
    always_comb begin
        logic po_busy;
        logic so_busy;
        logic put_slot_ok;
        logic [bgpt_pkg::SLOT_W-1:0] put_idx;

        commit     = 1'b0;
        wr         = '0;
        res_status = bgpt_pkg::STAT_OK;
        res_found  = 1'b0;
        res_pri    = '0;
        res_sec    = '0;

        po_busy     = (r_tok.po_key != '0) && (r_tok.po_key != r_tok.gid);
        so_busy     = (r_tok.so_key != '0) && (r_tok.so_key != r_tok.gid);
        put_slot_ok = r_tok.key_hit || r_tok.free_hit;
        put_idx     = r_tok.key_hit ? r_tok.hit_idx : r_tok.free_idx;

        wr.key = r_tok.gid;
        wr.pri = r_tok.pri;
        wr.sec = r_tok.sec;
        wr.idx = put_idx;

        case (r_state)
            bgpt_pkg::S_FINISH: begin
                commit = !r_out_valid || !i_stall;
                case (r_tok.op)
                    bgpt_pkg::OP_LOOKUP: begin
                        res_found = r_tok.key_hit;
                        if (r_tok.key_hit) begin
                            res_pri = r_tok.hit_pri;
                            res_sec = r_tok.hit_sec;
                        end
                    end
                    bgpt_pkg::OP_ADD: begin
                        if (r_tok.gid == '0) begin
                            res_status = bgpt_pkg::STAT_INVALID;
                        end else if (!r_tok.allow && r_tok.key_hit) begin
                            res_status = bgpt_pkg::STAT_EXISTS;
                        end else if (!r_tok.pknown || !r_tok.sknown) begin
                            res_status = bgpt_pkg::STAT_UNKNOWN;
                        end else if (po_busy || so_busy) begin
                            res_status = bgpt_pkg::STAT_INUSE;
                        end else if (!put_slot_ok) begin
                            res_status = bgpt_pkg::STAT_FULL;
                        end else begin
                            wr.en = commit;
                        end
                    end
                    bgpt_pkg::OP_CLEAR: begin
                        wr.clr = commit;
                    end
                    bgpt_pkg::OP_LOAD: begin
                        if (!put_slot_ok) begin
                            res_status = bgpt_pkg::STAT_FULL;
                        end else begin
                            wr.en = commit;
                        end
                    end
                    default: begin
                        res_status = bgpt_pkg::STAT_OK;
                    end
                endcase
            end
            default: begin
                commit = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bgpt_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: the finished token and the result beat.
    always_ff @(posedge i_clk) begin
        if (r_state == bgpt_pkg::S_SCAN && tok[MAX_GROUPS].valid) begin
            r_tok <= tok[MAX_GROUPS];
        end
        if (commit) begin
            r_status  <= res_status;
            r_found   <= res_found;
            r_pri_out <= res_pri;
            r_sec_out <= res_sec;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_found         = r_found;
    assign o_primary_out   = r_pri_out;
    assign o_secondary_out = r_sec_out;

endmodule

// ===== bench/buddy_group_pair_table_checker.sv =====
// Checker for the buddy group pair table: watches both channels, keeps its own copy
// of the table, predicts each reply and compares it with what the block returns.
// Depends on bgpt_pkg for the operation and status codes.
`timescale 1ns / 1ps

module buddy_group_pair_table_checker #(
    parameter int MAX_GROUPS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_group_id,
    input  logic [15:0] i_primary_target,
    input  logic [15:0] i_secondary_target,
    input  logic        i_allow_update,
    input  logic        i_primary_known,
    input  logic        i_secondary_known,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_status,
    input  logic        i_found,
    input  logic [15:0] i_primary_out,
    input  logic [15:0] i_secondary_out,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        bgpt_pkg::t_status status;
        logic              found;
        logic [15:0]       primary;
        logic [15:0]       secondary;
    } t_reply;

    t_reply      expected_replies[$];
    logic        slot_used [MAX_GROUPS];
    logic [15:0] slot_key  [MAX_GROUPS];
    logic [15:0] slot_pri  [MAX_GROUPS];
    logic [15:0] slot_sec  [MAX_GROUPS];
    int          mismatches = 0;

    function automatic int slot_of_key(logic [15:0] key);
        for (int s = 0; s < MAX_GROUPS; s++)
            if (slot_used[s] && slot_key[s] == key) return s;
        return -1;
    endfunction

    function automatic int first_free_slot();
        for (int s = 0; s < MAX_GROUPS; s++)
            if (!slot_used[s]) return s;
        return -1;
    endfunction

    // The lowest valid slot naming the target owns it; 0 means no owner.
    function automatic logic [15:0] owner_of_target(logic [15:0] target);
        for (int s = 0; s < MAX_GROUPS; s++)
            if (slot_used[s] && (slot_pri[s] == target || slot_sec[s] == target))
                return slot_key[s];
        return 16'h0000;
    endfunction

    function automatic bgpt_pkg::t_status store_pair(logic [15:0] key, logic [15:0] pri,
                                                     logic [15:0] sec);
        int s;
        s = slot_of_key(key);
        if (s < 0) s = first_free_slot();
        if (s < 0) return bgpt_pkg::STAT_FULL;
        slot_used[s] = 1'b1;
        slot_key[s]  = key;
        slot_pri[s]  = pri;
        slot_sec[s]  = sec;
        return bgpt_pkg::STAT_OK;
    endfunction

    function automatic t_reply predict_reply(bgpt_pkg::t_op op, logic [15:0] gid,
                                             logic [15:0] pri, logic [15:0] sec,
                                             logic allow, logic pknown, logic sknown);
        t_reply      r;
        int          s;
        logic [15:0] pri_owner;
        logic [15:0] sec_owner;
        r = '{bgpt_pkg::STAT_OK, 1'b0, 16'h0000, 16'h0000};
        case (op)
            bgpt_pkg::OP_LOOKUP: begin
                s = slot_of_key(gid);
                if (s >= 0) begin
                    r.found     = 1'b1;
                    r.primary   = slot_pri[s];
                    r.secondary = slot_sec[s];
                end
            end
            bgpt_pkg::OP_ADD: begin
                pri_owner = owner_of_target(pri);
                sec_owner = owner_of_target(sec);
                if (gid == 16'h0000)
                    r.status = bgpt_pkg::STAT_INVALID;
                else if (!allow && slot_of_key(gid) >= 0)
                    r.status = bgpt_pkg::STAT_EXISTS;
                else if (!pknown || !sknown)
                    r.status = bgpt_pkg::STAT_UNKNOWN;
                else if ((pri_owner != 16'h0000 && pri_owner != gid) ||
                         (sec_owner != 16'h0000 && sec_owner != gid))
                    r.status = bgpt_pkg::STAT_INUSE;
                else
                    r.status = store_pair(gid, pri, sec);
            end
            bgpt_pkg::OP_CLEAR: begin
                foreach (slot_used[i]) slot_used[i] = 1'b0;
            end
            default: begin
                r.status = store_pair(gid, pri, sec);
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_reply want;
        if (!i_rst_n) begin
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            expected_replies.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: reply with none expected: status %0d found %0d %h %h",
                                 $time, i_status, i_found, i_primary_out, i_secondary_out);
                end else begin
                    want = expected_replies.pop_front();
                    if (i_status !== want.status || i_found !== want.found ||
                        i_primary_out !== want.primary ||
                        i_secondary_out !== want.secondary) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: reply mismatch: expected status %0d found %0d ",
                                      "%h %h, got status %0d found %0d %h %h"},
                                     $time, want.status, want.found, want.primary,
                                     want.secondary, i_status, i_found, i_primary_out,
                                     i_secondary_out);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_replies.push_back(predict_reply(bgpt_pkg::t_op'(i_operation),
                                                         i_group_id,
                                                         i_primary_target,
                                                         i_secondary_target,
                                                         i_allow_update, i_primary_known,
                                                         i_secondary_known));
        end
        o_errors  <= mismatches;
        o_pending <= expected_replies.size();
    end

endmodule

// ===== bench/buddy_group_pair_table_tb.sv =====
// Top of the buddy group pair table testbench: clock, reset, stimulus and verdict.
// Depends on bgpt_pkg, the block itself and buddy_group_pair_table_checker.
`timescale 1ns / 1ps

module buddy_group_pair_table_tb;

    localparam int MAX_GROUPS  = 64;
    // Least number of stimulus beats in total, directed part included.
    localparam int BEAT_TARGET = 550;
    // Upper bound on the wait for outstanding replies once stimulus is over.
    localparam int DRAIN_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_operation = bgpt_pkg::OP_LOOKUP;
    logic [15:0] i_group_id = 16'h0000;
    logic [15:0] i_primary_target = 16'h0000;
    logic [15:0] i_secondary_target = 16'h0000;
    logic        i_allow_update = 1'b0;
    logic        i_primary_known = 1'b0;
    logic        i_secondary_known = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic        o_found;
    logic [15:0] o_primary_out;
    logic [15:0] o_secondary_out;

    int          error_count;
    int          replies_pending;
    int          beats_sent = 0;
    int          quiet_beats = 0;
    logic [15:0] key_pool [12];
    logic [15:0] target_pool [20];

    buddy_group_pair_table #(
        .MAX_GROUPS(MAX_GROUPS)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_operation        (i_operation),
        .i_group_id         (i_group_id),
        .i_primary_target   (i_primary_target),
        .i_secondary_target (i_secondary_target),
        .i_allow_update     (i_allow_update),
        .i_primary_known    (i_primary_known),
        .i_secondary_known  (i_secondary_known),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status           (o_status),
        .o_found            (o_found),
        .o_primary_out      (o_primary_out),
        .o_secondary_out    (o_secondary_out)
    );

    // The checker sits beside the block and sees exactly the beats that the
    // handshakes accept; this module never tells it what was sent.
    buddy_group_pair_table_checker #(
        .MAX_GROUPS(MAX_GROUPS)
    ) checker_i (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_valid),
        .i_in_stall         (o_stall),
        .i_operation        (i_operation),
        .i_group_id         (i_group_id),
        .i_primary_target   (i_primary_target),
        .i_secondary_target (i_secondary_target),
        .i_allow_update     (i_allow_update),
        .i_primary_known    (i_primary_known),
        .i_secondary_known  (i_secondary_known),
        .i_out_valid        (o_valid),
        .i_out_stall        (i_stall),
        .i_status           (o_status),
        .i_found            (o_found),
        .i_primary_out      (o_primary_out),
        .i_secondary_out    (o_secondary_out),
        .o_errors           (error_count),
        .o_pending          (replies_pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run: every beat paying the full
    // table walk plus the longest input gap and the longest output stall.
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 96) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Keys mostly come from a small pool so that adds run into existing groups
    // and lookups hit; a few are zero or anything at all.
    function automatic logic [15:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85) return key_pool[$urandom_range(0, 11)];
        if (roll < 90) return 16'h0000;
        return 16'($urandom_range(0, 65535));
    endfunction

    // Targets are drawn from a pool too, which makes ownership clashes common.
    function automatic logic [15:0] pick_target();
        if ($urandom_range(0, 9) == 0) return 16'($urandom_range(0, 65535));
        return target_pool[$urandom_range(0, 19)];
    endfunction

    // Presents one beat and holds it until the block takes it. Valid is only
    // dropped when a gap follows, so back-to-back beats keep it high.
    task automatic send(input bgpt_pkg::t_op op, input logic [15:0] gid,
                        input logic [15:0] pri, input logic [15:0] sec, input logic allow,
                        input logic pknown, input logic sknown);
        int gap;
        i_valid            <= 1'b1;
        i_operation        <= op;
        i_group_id         <= gid;
        i_primary_target   <= pri;
        i_secondary_target <= sec;
        i_allow_update     <= allow;
        i_primary_known    <= pknown;
        i_secondary_known  <= sknown;
        do @(posedge i_clk); while (o_stall);
        beats_sent++;
        if (quiet_beats > 0) begin
            quiet_beats--;
            gap = 0;
        end else begin
            gap = gap_len();
            if ($urandom_range(0, 49) == 0) quiet_beats = $urandom_range(10, 30);
        end
        if (gap > 0) begin
            // While idle the payload is junk; the block must ignore it.
            i_valid            <= 1'b0;
            i_operation        <= 2'($urandom_range(0, 3));
            i_group_id         <= 16'($urandom_range(0, 65535));
            i_primary_target   <= 16'($urandom_range(0, 65535));
            i_secondary_target <= 16'($urandom_range(0, 65535));
            i_allow_update     <= 1'($urandom_range(0, 1));
            i_primary_known    <= 1'($urandom_range(0, 1));
            i_secondary_known  <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_clear();
        send(bgpt_pkg::OP_CLEAR, 16'($urandom_range(0, 65535)),
             16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
             1'($urandom_range(0, 1)));
    endtask

    // Empties the table, fills every slot with fresh keys and disjoint targets,
    // then tries a new key both ways (table full), updates a stored group in
    // place while full, and looks up a stored key and the rejected one.
    task automatic fill_table();
        logic [15:0] key_base;
        logic [15:0] tgt_base;
        int          n;
        key_base = 16'($urandom_range(1, 65535 - MAX_GROUPS - 1));
        tgt_base = 16'($urandom_range(0, 65535 - 2 * MAX_GROUPS - 2));
        send_clear();
        for (n = 0; n < MAX_GROUPS; n++)
            send($urandom_range(0, 1) ? bgpt_pkg::OP_ADD : bgpt_pkg::OP_LOAD,
                 key_base + 16'(n), tgt_base + 16'(2 * n), tgt_base + 16'(2 * n + 1),
                 1'($urandom_range(0, 1)), 1'b1, 1'b1);
        send(bgpt_pkg::OP_ADD, key_base + 16'(MAX_GROUPS), tgt_base + 16'(2 * MAX_GROUPS),
             tgt_base + 16'(2 * MAX_GROUPS + 1), 1'b0, 1'b1, 1'b1);
        send(bgpt_pkg::OP_LOAD, key_base + 16'(MAX_GROUPS), tgt_base + 16'(2 * MAX_GROUPS),
             tgt_base + 16'(2 * MAX_GROUPS + 1), 1'b0, 1'b0, 1'b0);
        n = $urandom_range(0, MAX_GROUPS - 1);
        send(bgpt_pkg::OP_ADD, key_base + 16'(n), tgt_base + 16'(2 * n + 1),
             tgt_base + 16'(2 * n), 1'b1, 1'b1, 1'b1);
        send(bgpt_pkg::OP_LOOKUP, key_base + 16'(n), 16'h0000, 16'h0000,
             1'b0, 1'b0, 1'b0);
        send(bgpt_pkg::OP_LOOKUP, key_base + 16'(MAX_GROUPS), 16'h0000, 16'h0000,
             1'b0, 1'b0, 1'b0);
    endtask

    // Random output back-pressure. A stall is only raised when its length is
    // non-zero, so i_stall never sees two assignments in one time step.
    initial begin : reply_backpressure
        int open_len;
        int stall_len;
        forever begin
            open_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 8);
            i_stall <= 1'b0;
            repeat (open_len) @(posedge i_clk);
            stall_len = gap_len();
            if (stall_len > 0) begin
                i_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int            roll;
        int            waited;
        bgpt_pkg::t_op op;
        logic [15:0]   pri;

        foreach (key_pool[k]) key_pool[k] = 16'($urandom_range(1, 65535));
        foreach (target_pool[t]) target_pool[t] = 16'($urandom_range(0, 65535));
        key_pool[0]    = 16'hFFFF;
        key_pool[1]    = 16'h0001;
        target_pool[0] = 16'hFFFF;
        target_pool[1] = 16'h0000;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats. A lookup on the empty table finds nothing, and a
        // zero group ID is refused by add before anything else is checked.
        send(bgpt_pkg::OP_LOOKUP, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        send(bgpt_pkg::OP_ADD,    16'h0000, 16'h0001, 16'h0002, 1'b1, 1'b1, 1'b1);
        // First insert at the top key, then the same key again without and
        // with permission to update; the update names one target twice.
        send(bgpt_pkg::OP_ADD,    16'hFFFF, 16'hFFFF, 16'h0001, 1'b0, 1'b1, 1'b1);
        send(bgpt_pkg::OP_ADD,    16'hFFFF, 16'h0003, 16'h0004, 1'b0, 1'b1, 1'b1);
        send(bgpt_pkg::OP_ADD,    16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        send(bgpt_pkg::OP_LOOKUP, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
        // Unknown primary, unknown secondary, then each target owned elsewhere.
        send(bgpt_pkg::OP_ADD,    16'h0002, 16'h0005, 16'h0006, 1'b0, 1'b0, 1'b1);
        send(bgpt_pkg::OP_ADD,    16'h0002, 16'h0005, 16'h0006, 1'b0, 1'b1, 1'b0);
        send(bgpt_pkg::OP_ADD,    16'h0002, 16'hFFFF, 16'h0006, 1'b0, 1'b1, 1'b1);
        send(bgpt_pkg::OP_ADD,    16'h0002, 16'h0005, 16'hFFFF, 1'b0, 1'b1, 1'b1);
        // A load stores group zero with a shared target and no checks; a
        // target held only by group zero counts as free for a later add.
        send(bgpt_pkg::OP_LOAD,   16'h0000, 16'h0007, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        send(bgpt_pkg::OP_ADD,    16'h0003, 16'h0007, 16'h0008, 1'b0, 1'b1, 1'b1);
        send(bgpt_pkg::OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
        send(bgpt_pkg::OP_LOAD,   16'h8000, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0);
        send(bgpt_pkg::OP_LOOKUP, 16'h8000, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        // Clear, then check that nothing survived it and that a new group can
        // be added and looked up again.
        send(bgpt_pkg::OP_CLEAR,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        send(bgpt_pkg::OP_LOOKUP, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
        send(bgpt_pkg::OP_ADD,    16'h0001, 16'h0000, 16'hFFFF, 1'b0, 1'b1, 1'b1);
        send(bgpt_pkg::OP_LOOKUP, 16'h0001, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);

        // The random part opens with a complete fill so the full-table path is
        // always reached, then mixes well-formed traffic with noise.
        fill_table();
        while (beats_sent < BEAT_TARGET) begin
            roll = $urandom_range(0, 99);
            if (roll < 1) begin
                fill_table();
            end else if (roll < 4) begin
                send_clear();
            end else if (roll < 85) begin
                roll = $urandom_range(0, 99);
                op   = (roll < 35) ? bgpt_pkg::OP_LOOKUP
                     : (roll < 80) ? bgpt_pkg::OP_ADD : bgpt_pkg::OP_LOAD;
                pri  = pick_target();
                send(op, pick_key(), pri, ($urandom_range(0, 9) == 0) ? pri : pick_target(),
                     1'($urandom_range(0, 1)), $urandom_range(0, 9) != 0,
                     $urandom_range(0, 9) != 0);
            end else begin
                send(bgpt_pkg::t_op'(2'($urandom_range(0, 3))),
                     16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
            end
        end
        i_valid <= 1'b0;

        // Let the outstanding replies drain, then allow one more table walk so
        // that a stray late reply would still be caught.
        waited = 0;
        while (replies_pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (MAX_GROUPS + 8) @(posedge i_clk);

        if (error_count == 0 && replies_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/bgpt_pkg.sv
design/bgpt_cell.sv
design/buddy_group_pair_table.sv
bench/buddy_group_pair_table_checker.sv
bench/buddy_group_pair_table_tb.sv
